// ===== sv/sts_pkg.sv =====
// sts_pkg: shared types and constants of the software timer scheduler
// used by sts_ctrl, sts_dp and software_timer_scheduler; no dependencies
`default_nettype none

package sts_pkg;

    localparam int TIMER_SLOTS_DEF   = 16;
    localparam int MIN_PERIOD_MS_DEF = 16;
    localparam int MAX_OUT           = 16;
    localparam int FIRE_W            = $clog2(MAX_OUT);

    localparam int ID_W   = 32;
    localparam int DUR_W  = 32;
    localparam int TIME_W = 48;

    // operation codes carried in tuser
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // result kinds
    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] target;
        logic [DUR_W-1:0]  period;
        logic              rep;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREATE,
        ST_SCAN,
        ST_FIRE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic create_store;
        logic out_load;
        logic fire;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       needs_out;
        logic       out_free;
        logic       scan_done;
        logic       found;
        logic       last;
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/sts_ram.sv =====
// sts_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/sts_ctrl.sv =====
// sts_ctrl: operation sequencer of the timer scheduler
// depends on sts_pkg; drives sts_dp through t_cmd and reads t_stat
`default_nettype none

module sts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sts_pkg::t_stat i_stat,
    output sts_pkg::t_cmd      o_cmd
);

    sts_pkg::t_state r_state;
    sts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sts_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    // op values arrive with the transfer, seen here only as status
                    n_state = sts_pkg::ST_CREATE;
                end
            end
            sts_pkg::ST_CREATE: begin
                // the captured op decides what the item really is
                if (i_stat.op == sts_pkg::OP_DELETE || i_stat.op == sts_pkg::OP_TICK) begin
                    n_state = sts_pkg::ST_SCAN;
                end else if (i_stat.op != sts_pkg::OP_CREATE) begin
                    n_state = sts_pkg::ST_IDLE;
                end else if (!i_stat.needs_out || i_stat.out_free) begin
                    n_state = sts_pkg::ST_IDLE;
                end
            end
            sts_pkg::ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = (i_stat.op == sts_pkg::OP_TICK) ? sts_pkg::ST_FIRE
                                                              : sts_pkg::ST_IDLE;
                end
            end
            sts_pkg::ST_FIRE: begin
                if (!i_stat.found) begin
                    n_state = sts_pkg::ST_IDLE;
                end else if (i_stat.out_free) begin
                    n_state = i_stat.last ? sts_pkg::ST_IDLE : sts_pkg::ST_SCAN;
                end
            end
            default: n_state = sts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sts_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            sts_pkg::ST_CREATE: begin
                if (i_stat.op == sts_pkg::OP_DELETE || i_stat.op == sts_pkg::OP_TICK) begin
                    o_cmd.scan_start = 1'b1;
                end else if (i_stat.op == sts_pkg::OP_CREATE) begin
                    if (i_stat.needs_out) begin
                        o_cmd.out_load = i_stat.out_free;
                    end else begin
                        o_cmd.create_store = 1'b1;
                    end
                end
            end
            sts_pkg::ST_SCAN: begin
            end
            sts_pkg::ST_FIRE: begin
                if (i_stat.found && i_stat.out_free) begin
                    o_cmd.fire       = 1'b1;
                    o_cmd.scan_start = !i_stat.last;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sts_dp.sv =====
// sts_dp: slot table, scan pipeline, arithmetic and output register
// depends on sts_pkg and sts_ram; commanded by sts_ctrl
`default_nettype none

module sts_dp #(
    parameter int TIMER_SLOTS   = sts_pkg::TIMER_SLOTS_DEF,
    parameter int MIN_PERIOD_MS = sts_pkg::MIN_PERIOD_MS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sts_pkg::t_cmd              i_cmd,
    output sts_pkg::t_stat                  o_stat,
    input  wire logic [1:0]                 i_op,
    input  wire logic [sts_pkg::ID_W-1:0]   i_timer_id,
    input  wire logic [sts_pkg::DUR_W-1:0]  i_duration_ms,
    input  wire logic [sts_pkg::TIME_W-1:0] i_sched_time_ms,
    input  wire logic                       i_repeat_flag,
    input  wire logic [sts_pkg::TIME_W-1:0] i_now_ms,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_kind,
    output logic [sts_pkg::ID_W-1:0]        o_fired_id,
    output logic                            o_last
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);
    localparam logic [sts_pkg::DUR_W-1:0] MIN_PERIOD = sts_pkg::DUR_W'(MIN_PERIOD_MS);
    localparam logic [sts_pkg::TIME_W-1:0] TIME_MAX = '1;

    // captured item
    logic [1:0]                 r_op;
    logic [sts_pkg::ID_W-1:0]   r_id;
    logic [sts_pkg::DUR_W-1:0]  r_dur;
    logic [sts_pkg::TIME_W-1:0] r_sched;
    logic                       r_rep;
    logic [sts_pkg::TIME_W-1:0] r_now;

    logic [TIMER_SLOTS-1:0] r_valid;

    logic [SLOT_W-1:0] r_scan_idx;
    logic              r_scan_on;
    logic [SLOT_W-1:0] r_rd_idx;
    logic              r_rd_live;
    logic              r_found;
    logic [CNT_W-1:0]  r_due_cnt;
    logic [SLOT_W-1:0] r_best_idx;
    sts_pkg::t_entry   r_best;
    logic [sts_pkg::FIRE_W-1:0] r_fire_cnt;

    logic r_out_valid;

    logic [sts_pkg::DUR_W-1:0]  period;
    logic [sts_pkg::TIME_W:0]   create_sum;
    logic [sts_pkg::TIME_W-1:0] create_tgt;
    logic [sts_pkg::TIME_W:0]   resched_sum;
    logic [sts_pkg::TIME_W-1:0] resched_tgt;
    logic                       immediate;
    logic [SLOT_W-1:0]          free_idx;
    logic                       full;
    logic                       out_free;
    logic                       last;
    logic                       rd_valid;
    logic                       rd_due;
    logic                       del_hit;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    sts_pkg::t_entry   ram_wdata;
    sts_pkg::t_entry   ram_rdata;

    assign period      = (r_dur > MIN_PERIOD) ? r_dur : MIN_PERIOD;
    assign create_sum  = {1'b0, r_sched} + (sts_pkg::TIME_W + 1)'(period);
    assign create_tgt  = create_sum[sts_pkg::TIME_W] ? TIME_MAX
                                                     : create_sum[sts_pkg::TIME_W-1:0];
    assign resched_sum = {1'b0, r_now} + (sts_pkg::TIME_W + 1)'(r_best.period);
    assign resched_tgt = resched_sum[sts_pkg::TIME_W] ? TIME_MAX
                                                      : resched_sum[sts_pkg::TIME_W-1:0];
    assign immediate   = (r_dur == '0) && !r_rep;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SLOT_W'(i);
                full     = 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign last     = (r_due_cnt == CNT_W'(1))
                   || (r_fire_cnt == sts_pkg::FIRE_W'(sts_pkg::MAX_OUT - 1));

    assign rd_valid = r_rd_live && r_valid[r_rd_idx];
    assign rd_due   = rd_valid && (r_op == sts_pkg::OP_TICK) && (ram_rdata.target < r_now);
    assign del_hit  = rd_valid && (r_op == sts_pkg::OP_DELETE) && !r_found
                   && (ram_rdata.id == r_id);

    always_comb begin
        ram_we    = i_cmd.create_store || (i_cmd.fire && r_best.rep);
        ram_waddr = i_cmd.create_store ? free_idx : r_best_idx;
        ram_wdata = r_best;
        if (i_cmd.create_store) begin
            ram_wdata.id     = r_id;
            ram_wdata.target = create_tgt;
            ram_wdata.period = period;
            ram_wdata.rep    = r_rep;
        end else begin
            ram_wdata.target = resched_tgt;
        end
    end

    sts_ram #(
        .WIDTH (sts_pkg::ENTRY_W),
        .DEPTH (TIMER_SLOTS),
        .AW    (SLOT_W)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_id    <= i_timer_id;
            r_dur   <= i_duration_ms;
            r_sched <= i_sched_time_ms;
            r_rep   <= i_repeat_flag;
            r_now   <= i_now_ms;
        end
        r_rd_idx <= r_scan_idx;
        // earliest due target, strict compare keeps the lower slot on ties
        if (rd_due && (!r_found || ram_rdata.target < r_best.target)) begin
            r_best     <= ram_rdata;
            r_best_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_scan_idx <= '0;
            r_scan_on  <= 1'b0;
            r_rd_live  <= 1'b0;
            r_found    <= 1'b0;
            r_due_cnt  <= '0;
            r_fire_cnt <= '0;
        end else begin
            r_rd_live <= r_scan_on;
            if (i_cmd.capture) begin
                r_fire_cnt <= '0;
            end else if (i_cmd.fire) begin
                r_fire_cnt <= r_fire_cnt + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_scan_on  <= 1'b1;
                r_found    <= 1'b0;
                r_due_cnt  <= '0;
            end else begin
                if (r_scan_on) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                    if (r_scan_idx == LAST_SLOT) begin
                        r_scan_on <= 1'b0;
                    end
                end
                if (rd_due) begin
                    r_found   <= 1'b1;
                    r_due_cnt <= r_due_cnt + 1'b1;
                end
                if (del_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.create_store) begin
                r_valid[free_idx] <= 1'b1;
            end
            if (i_cmd.fire && !r_best.rep) begin
                r_valid[r_best_idx] <= 1'b0;
            end
            if (del_hit) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
        end
    end

    // result register parts the scan from the output stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_kind     <= immediate ? sts_pkg::KIND_FIRED : sts_pkg::KIND_REJECT;
            o_fired_id <= r_id;
            o_last     <= 1'b1;
        end else if (i_cmd.fire) begin
            o_kind     <= sts_pkg::KIND_FIRED;
            o_fired_id <= r_best.id;
            o_last     <= last;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat           = '0;
        o_stat.op        = r_op;
        o_stat.needs_out = immediate || full;
        o_stat.out_free  = out_free;
        o_stat.scan_done = r_rd_live && (r_rd_idx == LAST_SLOT);
        o_stat.found     = r_found;
        o_stat.last      = last;
    end

    a_fire_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |-> r_found && !r_scan_on && !r_rd_live)
        else $error("fire without a due timer or during a scan");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load || i_cmd.fire) |-> out_free)
        else $error("result register overwritten");

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.create_store |-> !full && !immediate)
        else $error("create stored into a full table");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.scan_done && !i_cmd.scan_start) |=> !r_rd_live)
        else $error("scan ran past the last slot");

endmodule

`default_nettype wire

// ===== sv/software_timer_scheduler.sv =====
// software_timer_scheduler: top level of the timer table and tick scheduler
// depends on sts_pkg, sts_ctrl, sts_dp (and through it sts_ram)
//
// One operation is taken at a time on the slave stream, selected by tuser:
// create stores a timer in the lowest free slot (or fires it at once when it
// has zero duration and no repeat, or answers with a reject when the table is
// full), delete frees the lowest slot holding the id, and tick fires every
// due timer earliest first, at most 16 per tick, one result transfer each,
// tlast on the final one. A delete scans the whole slot table, and a tick
// scans it once and then again for every fired timer after the first; the
// slot memory has a single read port, scanned one slot per cycle. Results
// wait in an output register, so a stalled master stream holds the scheduler.
`default_nettype none

module software_timer_scheduler #(
    parameter int TIMER_SLOTS   = sts_pkg::TIMER_SLOTS_DEF,
    parameter int MIN_PERIOD_MS = sts_pkg::MIN_PERIOD_MS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // timer_id[31:0], duration_ms[63:32], sched_time_ms[111:64],
    // repeat_flag[112], now_ms[160:113], zero pad[167:161]
    input  wire logic [167:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // fired_id[31:0]
    output logic [31:0]       m_axis_tdata,
    // kind[0]
    output logic [0:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    sts_pkg::t_cmd  cmd;
    sts_pkg::t_stat stat;

    sts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sts_dp #(
        .TIMER_SLOTS   (TIMER_SLOTS),
        .MIN_PERIOD_MS (MIN_PERIOD_MS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (s_axis_tuser),
        .i_timer_id      (s_axis_tdata[31:0]),
        .i_duration_ms   (s_axis_tdata[63:32]),
        .i_sched_time_ms (s_axis_tdata[111:64]),
        .i_repeat_flag   (s_axis_tdata[112]),
        .i_now_ms        (s_axis_tdata[160:113]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_kind          (m_axis_tuser[0]),
        .o_fired_id      (m_axis_tdata),
        .o_last          (m_axis_tlast)
    );

endmodule

`default_nettype wire
